### hdl/mftt_pkg.sv
// shared types and constants for the motor feedback turn tracker
// no dependencies; imported by every module of the block

package mftt_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// apb word address of the stale limit register
	localparam logic REG_STALE_LIMIT = 1'b0;
	localparam logic [15:0] STALE_LIMIT_RESET = 16'd10;

	// one accepted feedback frame
	typedef struct packed {
		logic               bus;
		logic [2:0]         motor;
		logic [12:0]        angle;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		logic [7:0]         temperature;
		logic [31:0]        now;
	} frame_t;

	// queue status towards the front end
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

### hdl/mftt_front.sv
// front end: takes start transfers, drops frames for slots that do not exist
// depends on mftt_pkg

module mftt_front #(
	parameter int BUSES          = 2,
	parameter int MOTORS_PER_BUS = 8
) (
	input  logic                 start,
	output logic                 busy,
	input  logic                 bus_index,
	input  logic [2:0]           motor_index,
	input  logic [12:0]          angle_code,
	input  logic signed [15:0]   speed_rpm,
	input  logic signed [15:0]   current_raw,
	input  logic [7:0]           temperature,
	input  logic [31:0]          now_tick,
	input  mftt_pkg::queue_stat_t q_stat,
	output logic                 push,
	output mftt_pkg::frame_t     frame
);
	import mftt_pkg::*;

	logic in_range;

	assign in_range = (32'(bus_index) < 32'(BUSES)) && (32'(motor_index) < 32'(MOTORS_PER_BUS));

	assign busy = q_stat.full;
	// out of range frames are taken and dropped
	assign push = start && !q_stat.full && in_range;

	assign frame.bus         = bus_index;
	assign frame.motor       = motor_index;
	assign frame.angle       = angle_code;
	assign frame.speed       = speed_rpm;
	assign frame.current     = current_raw;
	assign frame.temperature = temperature;
	assign frame.now         = now_tick;

endmodule

### hdl/mftt_queue.sv
// short frame queue between front and back end
// depends on mftt_pkg

module mftt_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mftt_pkg::frame_t      wr_frame,
	input  logic                  pop,
	output mftt_pkg::frame_t      rd_frame,
	output mftt_pkg::queue_stat_t stat
);
	import mftt_pkg::*;

	frame_t                 entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign stat.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_frame   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + QUEUE_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QUEUE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wr_frame;
	end

endmodule

### hdl/mftt_back.sv
// back end: read-modify-write of the per slot turn table, registered result
// depends on mftt_pkg

module mftt_back #(
	parameter int BUSES          = 2,
	parameter int MOTORS_PER_BUS = 8,
	parameter int ENCODER_COUNTS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  mftt_pkg::frame_t   frame,
	input  logic [15:0]        stale_limit,
	output logic               pop,
	output logic               done,
	output logic               out_bus,
	output logic [2:0]         out_motor,
	output logic [12:0]        out_angle,
	output logic signed [15:0] out_speed,
	output logic signed [15:0] out_current,
	output logic [7:0]         out_temperature,
	output logic signed [31:0] turns,
	output logic               restarted
);
	import mftt_pkg::*;

	localparam int SLOTS  = BUSES * MOTORS_PER_BUS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic signed [17:0] ENC_LIM = 18'(ENCODER_COUNTS);

	logic [SLOTS-1:0]   active_q;
	logic [12:0]        last_angle_q [SLOTS];
	logic [31:0]        last_seen_q  [SLOTS];
	logic [31:0]        turn_q       [SLOTS];

	logic [5:0]         slot_full;
	logic [SLOT_W-1:0]  slot;
	logic [31:0]        age;
	logic               restart;
	logic signed [17:0] step2;
	logic [31:0]        turn_cur;
	logic [31:0]        turn_next;
	logic               done_q;

	assign pop       = valid;
	assign slot_full = 6'(frame.bus) * 6'(MOTORS_PER_BUS) + 6'(frame.motor);
	assign slot      = slot_full[SLOT_W-1:0];
	assign age       = frame.now - last_seen_q[slot];
	assign restart   = !active_q[slot] || (age > 32'(stale_limit));
	// twice the angle step, compared against a whole revolution
	assign step2     = 18'(signed'({5'b0, frame.angle}) - signed'({5'b0, last_angle_q[slot]})) <<< 1;
	assign turn_cur  = turn_q[slot];

	always_comb begin
		if (restart)
			turn_next = '0;
		else if (step2 > ENC_LIM)
			turn_next = turn_cur - 32'd1;
		else if (step2 < -ENC_LIM)
			turn_next = turn_cur + 32'd1;
		else
			turn_next = turn_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= valid;
			if (valid)
				active_q[slot] <= 1'b1;
		end
	end

	// table contents only matter once the slot is active
	always_ff @(posedge clk) begin
		if (valid) begin
			last_angle_q[slot] <= frame.angle;
			last_seen_q[slot]  <= frame.now;
			turn_q[slot]       <= turn_next;
			out_bus            <= frame.bus;
			out_motor          <= frame.motor;
			out_angle          <= frame.angle;
			out_speed          <= frame.speed;
			out_current        <= frame.current;
			out_temperature    <= frame.temperature;
			turns              <= signed'(turn_next);
			restarted          <= restart;
		end
	end

	assign done = done_q;

endmodule

### hdl/motor_feedback_turn_tracker_core.sv
// channel   | handshake                      | payload
// frame in  | start / busy, taken when !busy | bus_index .. now_tick
// result    | done strobe, one cycle         | out_bus .. restarted
// config    | apb, pready always high        | stale_limit at paddr 0
//
// a frame goes through the front end into a two entry queue, the back end
// takes it the next cycle and updates the slot table; the frame passes the queue
// entry and then the result registers before it shows, one frame per cycle sustained
// busy rises only while the queue is full; results cannot be held off
// reset clears the slot active flags and the queue, stale_limit goes to 10
// depends on mftt_pkg, mftt_front, mftt_queue, mftt_back

module motor_feedback_turn_tracker_core #(
	parameter int BUSES          = 2,
	parameter int MOTORS_PER_BUS = 8,
	parameter int ENCODER_COUNTS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               bus_index,
	input  logic [2:0]         motor_index,
	input  logic [12:0]        angle_code,
	input  logic signed [15:0] speed_rpm,
	input  logic signed [15:0] current_raw,
	input  logic [7:0]         temperature,
	input  logic [31:0]        now_tick,
	output logic               done,
	output logic               out_bus,
	output logic [2:0]         out_motor,
	output logic [12:0]        out_angle,
	output logic signed [15:0] out_speed,
	output logic signed [15:0] out_current,
	output logic [7:0]         out_temperature,
	output logic signed [31:0] turns,
	output logic               restarted
);
	import mftt_pkg::*;

	logic        [15:0] stale_limit_q;
	logic               push;
	frame_t             in_frame;
	frame_t             q_frame;
	queue_stat_t        q_stat;
	logic               q_valid;
	logic               pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= STALE_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STALE_LIMIT)) begin
			stale_limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_STALE_LIMIT)
			prdata = {16'b0, stale_limit_q};
		else
			prdata = '0;
	end

	mftt_front #(
		.BUSES          (BUSES),
		.MOTORS_PER_BUS (MOTORS_PER_BUS)
	) u_front (
		.start       (start),
		.busy        (busy),
		.bus_index   (bus_index),
		.motor_index (motor_index),
		.angle_code  (angle_code),
		.speed_rpm   (speed_rpm),
		.current_raw (current_raw),
		.temperature (temperature),
		.now_tick    (now_tick),
		.q_stat      (q_stat),
		.push        (push),
		.frame       (in_frame)
	);

	mftt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (in_frame),
		.pop      (pop),
		.rd_frame (q_frame),
		.stat     (q_stat)
	);

	assign q_valid = !q_stat.empty;

	mftt_back #(
		.BUSES          (BUSES),
		.MOTORS_PER_BUS (MOTORS_PER_BUS),
		.ENCODER_COUNTS (ENCODER_COUNTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid           (q_valid),
		.frame           (q_frame),
		.stale_limit     (stale_limit_q),
		.pop             (pop),
		.done            (done),
		.out_bus         (out_bus),
		.out_motor       (out_motor),
		.out_angle       (out_angle),
		.out_speed       (out_speed),
		.out_current     (out_current),
		.out_temperature (out_temperature),
		.turns           (turns),
		.restarted       (restarted)
	);

`ifndef SYNTHESIS
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && restarted |-> turns == 32'sd0)
		else $error("restarted slot reports non-zero turns");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |=> done)
		else $error("queued frame gave no result");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("frame pushed into full queue");
`endif

endmodule
